// File: rtl/core/nmos_6502_alu_register_unit_defines.svh
// Assertion macros for the 6502 execute unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef NMOS_6502_ALU_REGISTER_UNIT_DEFINES_SVH
`define NMOS_6502_ALU_REGISTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NM6502_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NM6502_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/nm6502_pkg.sv
// Shared types and constants of the 6502 execute unit.
// No dependencies; used by the ALU, the top level and the testbench.
package nm6502_pkg;

  typedef enum logic [4:0] {
    FN_NOP  = 5'd0,
    FN_LDA  = 5'd1,
    FN_LDX  = 5'd2,
    FN_LDY  = 5'd3,
    FN_AND  = 5'd4,
    FN_ORA  = 5'd5,
    FN_EOR  = 5'd6,
    FN_ADC  = 5'd7,
    FN_SBC  = 5'd8,
    FN_CMP  = 5'd9,
    FN_CPX  = 5'd10,
    FN_CPY  = 5'd11,
    FN_INX  = 5'd12,
    FN_INY  = 5'd13,
    FN_DEX  = 5'd14,
    FN_DEY  = 5'd15,
    FN_TAX  = 5'd16,
    FN_TAY  = 5'd17,
    FN_TXA  = 5'd18,
    FN_TYA  = 5'd19,
    FN_TSX  = 5'd20,
    FN_TXS  = 5'd21,
    FN_SED  = 5'd22,
    FN_CLD  = 5'd23,
    FN_LDST = 5'd24,
    FN_RDST = 5'd25
  } func_e;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [7:0] FLAGS_ONE_MASK  = 8'h20;
  localparam logic [7:0] FLAGS_READ_MASK = 8'h30;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic [7:0] sp;
    logic [7:0] flags;
  } regs_t;

  localparam regs_t REGS_RESET = '{acc: 8'h00, xreg: 8'h00, yreg: 8'h00,
                                   sp: 8'hFF, flags: 8'h20};

endpackage

// File: rtl/core/nm6502_if.sv
// Valid/ready channel interfaces of the 6502 execute unit.
// Self-contained; one carries operation words in, the other result words out.
interface nm6502_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] func;
  logic [7:0] operand;

  modport source (output valid, output func, output operand, input ready);
  modport sink (input valid, input func, input operand, output ready);
endinterface

interface nm6502_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic [7:0] acc_out;
  logic [7:0] x_out;
  logic [7:0] y_out;
  logic [7:0] sp_out;
  logic [7:0] flags_out;

  modport source (output valid, output result, output acc_out, output x_out,
                  output y_out, output sp_out, output flags_out, input ready);
  modport sink (input valid, input result, input acc_out, input x_out,
                input y_out, input sp_out, input flags_out, output ready);
endinterface

// File: rtl/core/nm6502_alu.sv
// Combinational ALU of the 6502 execute unit: next register state and result byte.
// Depends on nm6502_pkg.
module nm6502_alu (
  input  logic [4:0]         func_i,
  input  logic [7:0]         operand_i,
  input  nm6502_pkg::regs_t  cur_i,
  output nm6502_pkg::regs_t  nxt_o,
  output logic [7:0]         result_o
);
  import nm6502_pkg::*;

  logic [7:0] a;
  logic [7:0] b;
  logic       cin;

  logic [8:0] bin_sum;
  logic [4:0] dadd_lo;
  logic [5:0] dadd_lo_adj;
  logic [8:0] dadd_s;
  logic [9:0] dadd_s_adj;

  logic [8:0] bin_diff;
  logic [4:0] dsub_lo;
  logic [8:0] dsub_hi;
  logic [8:0] dsub_d;
  logic [8:0] dsub_adj;

  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;

  assign a   = cur_i.acc;
  assign b   = operand_i;
  assign cin = cur_i.flags[FLAG_C];

  always_comb begin
    bin_sum     = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    dadd_lo     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    dadd_lo_adj = (dadd_lo > 5'd9) ? ({1'b0, dadd_lo} + 6'd6) : {1'b0, dadd_lo};
    dadd_s      = {5'd0, dadd_lo_adj[3:0]} + {1'b0, a[7:4], 4'd0} + {1'b0, b[7:4], 4'd0}
                + ((dadd_lo_adj > 6'd15) ? 9'h010 : 9'h000);
    dadd_s_adj  = ({dadd_s[8:4], 4'd0} > 9'h090) ? ({1'b0, dadd_s} + 10'h060)
                                                  : {1'b0, dadd_s};

    bin_diff = {1'b0, a} - {1'b0, b} - {8'd0, ~cin};
    dsub_lo  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ~cin};
    dsub_hi  = {1'b0, a[7:4], 4'd0} - {1'b0, b[7:4], 4'd0}
             - (dsub_lo[4] ? 9'h010 : 9'h000);
    dsub_d   = {dsub_hi[8:4], (dsub_lo[4] ? (dsub_lo[3:0] - 4'd6) : dsub_lo[3:0])};
    dsub_adj = dsub_d[8] ? (dsub_d - 9'h060) : dsub_d;
  end

  always_comb begin
    unique case (func_i)
      FN_CPX:  cmp_reg = cur_i.xreg;
      FN_CPY:  cmp_reg = cur_i.yreg;
      default: cmp_reg = cur_i.acc;
    endcase
    cmp_diff = {1'b0, cmp_reg} - {1'b0, operand_i};
  end

  function automatic logic [7:0] with_nz(logic [7:0] fl, logic [7:0] v);
    logic [7:0] f;
    f = fl;
    f[FLAG_Z] = (v == 8'h00);
    f[FLAG_N] = v[7];
    return f;
  endfunction

  always_comb begin
    nxt_o    = cur_i;
    result_o = 8'h00;
    unique case (func_e'(func_i))
      FN_LDA: begin
        nxt_o.acc = operand_i;
      end
      FN_LDX: begin
        nxt_o.xreg = operand_i;
      end
      FN_LDY: begin
        nxt_o.yreg = operand_i;
      end
      FN_AND: begin
        nxt_o.acc = a & b;
      end
      FN_ORA: begin
        nxt_o.acc = a | b;
      end
      FN_EOR: begin
        nxt_o.acc = a ^ b;
      end
      FN_ADC: begin
        if (!cur_i.flags[FLAG_D]) begin
          nxt_o.acc           = bin_sum[7:0];
          nxt_o.flags         = with_nz(cur_i.flags, bin_sum[7:0]);
          nxt_o.flags[FLAG_C] = bin_sum[8];
          nxt_o.flags[FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ bin_sum[7]);
        end else begin
          nxt_o.acc           = dadd_s_adj[7:0];
          nxt_o.flags[FLAG_Z] = (bin_sum[7:0] == 8'h00);
          nxt_o.flags[FLAG_N] = dadd_s[7];
          nxt_o.flags[FLAG_V] = (a[7] ^ dadd_s[7]) & ~(a[7] ^ b[7]);
          nxt_o.flags[FLAG_C] = dadd_s_adj[9] | dadd_s_adj[8];
        end
      end
      FN_SBC: begin
        nxt_o.acc           = cur_i.flags[FLAG_D] ? dsub_adj[7:0] : bin_diff[7:0];
        nxt_o.flags         = with_nz(cur_i.flags, bin_diff[7:0]);
        nxt_o.flags[FLAG_C] = ~bin_diff[8];
        nxt_o.flags[FLAG_V] = (a[7] ^ b[7]) & (a[7] ^ bin_diff[7]);
      end
      FN_CMP, FN_CPX, FN_CPY: begin
        nxt_o.flags         = with_nz(cur_i.flags, cmp_diff[7:0]);
        nxt_o.flags[FLAG_C] = ~cmp_diff[8];
      end
      FN_INX: begin
        nxt_o.xreg = cur_i.xreg + 8'd1;
      end
      FN_INY: begin
        nxt_o.yreg = cur_i.yreg + 8'd1;
      end
      FN_DEX: begin
        nxt_o.xreg = cur_i.xreg - 8'd1;
      end
      FN_DEY: begin
        nxt_o.yreg = cur_i.yreg - 8'd1;
      end
      FN_TAX: begin
        nxt_o.xreg = cur_i.acc;
      end
      FN_TAY: begin
        nxt_o.yreg = cur_i.acc;
      end
      FN_TXA: begin
        nxt_o.acc = cur_i.xreg;
      end
      FN_TYA: begin
        nxt_o.acc = cur_i.yreg;
      end
      FN_TSX: begin
        nxt_o.xreg = cur_i.sp;
      end
      FN_TXS: begin
        nxt_o.sp = cur_i.xreg;
        result_o = cur_i.xreg;
      end
      FN_SED: begin
        nxt_o.flags[FLAG_D] = 1'b1;
      end
      FN_CLD: begin
        nxt_o.flags[FLAG_D] = 1'b0;
      end
      FN_LDST: begin
        nxt_o.flags = operand_i | FLAGS_ONE_MASK;
        result_o    = operand_i | FLAGS_ONE_MASK;
      end
      FN_RDST: begin
        result_o = cur_i.flags | FLAGS_READ_MASK;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase

    unique case (func_e'(func_i))
      FN_LDA, FN_AND, FN_ORA, FN_EOR, FN_TXA, FN_TYA: begin
        nxt_o.flags = with_nz(cur_i.flags, nxt_o.acc);
        result_o    = nxt_o.acc;
      end
      FN_ADC, FN_SBC: begin
        result_o = nxt_o.acc;
      end
      FN_LDX, FN_INX, FN_DEX, FN_TAX, FN_TSX: begin
        nxt_o.flags = with_nz(cur_i.flags, nxt_o.xreg);
        result_o    = nxt_o.xreg;
      end
      FN_LDY, FN_INY, FN_DEY, FN_TAY: begin
        nxt_o.flags = with_nz(cur_i.flags, nxt_o.yreg);
        result_o    = nxt_o.yreg;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/nmos_6502_alu_register_unit.sv
// Top level of the 6502 execute unit: input stage, ALU and output stage.
// Depends on nm6502_pkg, the nm6502 channel interfaces, nm6502_alu and the defines header.
// A word is held in the input stage, then its result is registered in the output stage.
// Throughput: one word per cycle while the output is taken; the register file feeds
// the ALU and is written back in the same cycle, so consecutive words see updated state.
// Reset: asynchronous, active low; A, X, Y = 0, SP = 0xFF, status = 0x20, stages empty.
module nmos_6502_alu_register_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  nm6502_in_if.sink          in_i,
  nm6502_out_if.source       out_o
);
  import nm6502_pkg::*;
  `include "nmos_6502_alu_register_unit_defines.svh"

  logic       s0_valid_q;
  logic       s0_valid_d;
  logic [4:0] s0_func_q;
  logic [7:0] s0_operand_q;
  logic       out_valid_q;
  logic       out_valid_d;
  logic [7:0] result_q;
  regs_t      regs_q;
  regs_t      regs_d;
  logic [7:0] alu_result;
  logic       advance;
  logic       s0_fire;
  logic       in_fire;

  assign advance    = !out_valid_q || out_o.ready;
  assign s0_fire    = s0_valid_q && advance;
  assign in_i.ready = !s0_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  nm6502_alu u_alu (
    .func_i    (s0_func_q),
    .operand_i (s0_operand_q),
    .cur_i     (regs_q),
    .nxt_o     (regs_d),
    .result_o  (alu_result)
  );

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_fire) begin
      s0_valid_d = 1'b1;
    end else if (s0_fire) begin
      s0_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s0_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      regs_q      <= REGS_RESET;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
      if (s0_fire) begin
        regs_q <= regs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_func_q    <= in_i.func;
      s0_operand_q <= in_i.operand;
    end
    if (s0_fire) begin
      result_q <= alu_result;
    end
  end

  // The register file only moves when a word is executed, so it always
  // matches the word held in the output stage.
  assign out_o.valid     = out_valid_q;
  assign out_o.result    = result_q;
  assign out_o.acc_out   = regs_q.acc;
  assign out_o.x_out     = regs_q.xreg;
  assign out_o.y_out     = regs_q.yreg;
  assign out_o.sp_out    = regs_q.sp;
  assign out_o.flags_out = regs_q.flags;

  `NM6502_ASSERT_NEXT(a_regs_hold, clk_i, rst_ni, !s0_fire, $stable(regs_q), "state moved")
  `NM6502_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, !advance, !s0_fire, "result overwritten")
  `NM6502_ASSERT_NEXT(a_fire_valid, clk_i, rst_ni, s0_fire, out_valid_q, "no result for word")
  `NM6502_ASSERT_NOW(a_flag_one, clk_i, rst_ni, 1'b1, regs_q.flags[5], "status bit 5 cleared")

endmodule

// File: dv/testbench.sv
// Testbench for the 6502 execute unit: directed and random operation words,
// with every result word checked field by field against a register-level predictor.
// Depends on nm6502_pkg, the nm6502 channel interfaces and nmos_6502_alu_register_unit.
import nm6502_pkg::*;

typedef struct packed {
  logic [7:0] result;
  logic [7:0] acc;
  logic [7:0] xreg;
  logic [7:0] yreg;
  logic [7:0] sp;
  logic [7:0] flags;
} result_word_t;

class alu_scoreboard;
  regs_t        regs;
  result_word_t expected_q[$];
  int unsigned  failures;

  function new();
    regs = REGS_RESET;
    failures = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void put_nz(logic [7:0] v);
    regs.flags[FLAG_Z] = (v == 8'h00);
    regs.flags[FLAG_N] = v[7];
  endfunction

  function void compare_reg(logic [7:0] r, logic [7:0] op);
    logic [7:0] d;
    d = r - op;
    regs.flags[FLAG_C] = (r >= op);
    put_nz(d);
  endfunction

  function void add_with_carry(logic [7:0] op);
    int unsigned a, b, c, bin, lo, s;
    logic [7:0] r;
    a = regs.acc;
    b = op;
    c = regs.flags[FLAG_C];
    bin = a + b + c;
    if (!regs.flags[FLAG_D]) begin
      r = bin[7:0];
      regs.flags[FLAG_C] = (bin > 'hFF);
      put_nz(r);
      regs.flags[FLAG_V] = ((~(a ^ b)) & (a ^ r) & 'h80) != 0;
      regs.acc = r;
    end else begin
      lo = (a & 'h0F) + (b & 'h0F) + c;
      if (lo > 9) lo += 6;
      s = (lo & 'h0F) + (a & 'hF0) + (b & 'hF0) + ((lo > 'h0F) ? 'h10 : 0);
      // Decimal add: Z from the binary sum, N and V before the high-digit fix.
      regs.flags[FLAG_Z] = ((bin & 'hFF) == 0);
      regs.flags[FLAG_N] = ((s & 'h80) != 0);
      regs.flags[FLAG_V] = ((a ^ s) & 'h80) != 0 && ((a ^ b) & 'h80) == 0;
      if ((s & 'h1F0) > 'h90) s += 'h60;
      regs.flags[FLAG_C] = ((s & 'hFF0) > 'hF0);
      regs.acc = s[7:0];
    end
  endfunction

  function void sub_with_borrow(logic [7:0] op);
    int unsigned a, b, c, diff, d;
    logic [7:0] r;
    a = regs.acc;
    b = op;
    c = regs.flags[FLAG_C];
    diff = (a - b - (1 - c)) & 'hFFFF;
    r = diff[7:0];
    // All flags come from the binary difference, in decimal mode too.
    regs.flags[FLAG_C] = (diff < 'h100);
    put_nz(r);
    regs.flags[FLAG_V] = ((a ^ b) & (a ^ r) & 'h80) != 0;
    if (!regs.flags[FLAG_D]) begin
      regs.acc = r;
    end else begin
      d = ((a & 'h0F) - (b & 'h0F) - (1 - c)) & 'hFFFF;
      if ((d & 'h10) != 0) begin
        d = (((d - 6) & 'h0F) | ((a & 'hF0) - (b & 'hF0) - 'h10)) & 'hFFFF;
      end else begin
        d = ((d & 'h0F) | ((a & 'hF0) - (b & 'hF0))) & 'hFFFF;
      end
      if ((d & 'h100) != 0) d = (d - 'h60) & 'hFFFF;
      regs.acc = d[7:0];
    end
  endfunction

  function void note_word(logic [4:0] code, logic [7:0] op);
    result_word_t w;
    logic [7:0] res;
    res = 8'h00;
    case (code)
      FN_LDA:  begin regs.acc = op; put_nz(regs.acc); res = regs.acc; end
      FN_LDX:  begin regs.xreg = op; put_nz(regs.xreg); res = regs.xreg; end
      FN_LDY:  begin regs.yreg = op; put_nz(regs.yreg); res = regs.yreg; end
      FN_AND:  begin regs.acc = regs.acc & op; put_nz(regs.acc); res = regs.acc; end
      FN_ORA:  begin regs.acc = regs.acc | op; put_nz(regs.acc); res = regs.acc; end
      FN_EOR:  begin regs.acc = regs.acc ^ op; put_nz(regs.acc); res = regs.acc; end
      FN_ADC:  begin add_with_carry(op); res = regs.acc; end
      FN_SBC:  begin sub_with_borrow(op); res = regs.acc; end
      FN_CMP:  compare_reg(regs.acc, op);
      FN_CPX:  compare_reg(regs.xreg, op);
      FN_CPY:  compare_reg(regs.yreg, op);
      FN_INX:  begin regs.xreg = regs.xreg + 8'd1; put_nz(regs.xreg); res = regs.xreg; end
      FN_INY:  begin regs.yreg = regs.yreg + 8'd1; put_nz(regs.yreg); res = regs.yreg; end
      FN_DEX:  begin regs.xreg = regs.xreg - 8'd1; put_nz(regs.xreg); res = regs.xreg; end
      FN_DEY:  begin regs.yreg = regs.yreg - 8'd1; put_nz(regs.yreg); res = regs.yreg; end
      FN_TAX:  begin regs.xreg = regs.acc; put_nz(regs.xreg); res = regs.xreg; end
      FN_TAY:  begin regs.yreg = regs.acc; put_nz(regs.yreg); res = regs.yreg; end
      FN_TXA:  begin regs.acc = regs.xreg; put_nz(regs.acc); res = regs.acc; end
      FN_TYA:  begin regs.acc = regs.yreg; put_nz(regs.acc); res = regs.acc; end
      FN_TSX:  begin regs.xreg = regs.sp; put_nz(regs.xreg); res = regs.xreg; end
      FN_TXS:  begin regs.sp = regs.xreg; res = regs.sp; end
      FN_SED:  regs.flags[FLAG_D] = 1'b1;
      FN_CLD:  regs.flags[FLAG_D] = 1'b0;
      FN_LDST: begin regs.flags = op | FLAGS_ONE_MASK; res = regs.flags; end
      FN_RDST: res = regs.flags | FLAGS_READ_MASK;
      default: ;
    endcase
    w.result = res;
    w.acc    = regs.acc;
    w.xreg   = regs.xreg;
    w.yreg   = regs.yreg;
    w.sp     = regs.sp;
    w.flags  = regs.flags;
    expected_q.push_back(w);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
    end
  endfunction

  function void check_word(result_word_t got);
    result_word_t want;
    if (expected_q.size() == 0) begin
      failures++;
      $display("%0t: unexpected result word, expected none, actual %012h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    compare_field("result", want.result, got.result);
    compare_field("acc_out", want.acc, got.acc);
    compare_field("x_out", want.xreg, got.xreg);
    compare_field("y_out", want.yreg, got.yreg);
    compare_field("sp_out", want.sp, got.sp);
    compare_field("flags_out", want.flags, got.flags);
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned PHASE_WORDS   = 300;
  localparam int unsigned DRAIN_CYCLES  = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles;
  alu_scoreboard board;

  nm6502_in_if  in_ch();
  nm6502_out_if out_ch();

  nmos_6502_alu_register_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_word({out_ch.result, out_ch.acc_out, out_ch.x_out, out_ch.y_out,
                        out_ch.sp_out, out_ch.flags_out});
    end
  end

  task automatic send_word(logic [4:0] code, logic [7:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= code;
    in_ch.operand <= op;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_word(code, op);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_directed();
    logic [12:0] words[$];
    words = '{
      {FN_RDST, 8'h00}, {FN_LDA, 8'h00}, {FN_LDA, 8'h80}, {FN_LDX, 8'hFF},
      {FN_INX, 8'h00},  {FN_DEX, 8'h00}, {FN_LDY, 8'h00}, {FN_DEY, 8'h00},
      {FN_INY, 8'h00},  {FN_AND, 8'hFF}, {FN_ORA, 8'h7F}, {FN_EOR, 8'h55},
      {FN_ADC, 8'h7F},  {FN_SBC, 8'h80}, {FN_CMP, 8'hFF}, {FN_CPX, 8'h00},
      {FN_CPY, 8'h80},  {FN_TAX, 8'h00}, {FN_TAY, 8'h00}, {FN_TXA, 8'h00},
      {FN_TYA, 8'h00},  {FN_TSX, 8'h00}, {FN_LDX, 8'h42}, {FN_TXS, 8'h00},
      {FN_SED, 8'h00},  {FN_LDA, 8'h99}, {FN_ADC, 8'h01}, {FN_ADC, 8'hFA},
      {FN_SBC, 8'h01},  {FN_SBC, 8'hAF}, {FN_CLD, 8'h00}, {FN_LDST, 8'hFF},
      {FN_RDST, 8'h00}, {FN_LDST, 8'h00}, {5'd26, 8'hFF}, {5'd31, 8'h00}
    };
    foreach (words[i]) send_word(words[i][12:8], words[i][7:0]);
  endtask

  task automatic send_random(int unsigned count);
    logic [4:0] code;
    logic [7:0] op;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 35) code = $urandom_range(1) ? FN_ADC : FN_SBC;
      else if (pick < 45) code = $urandom_range(1) ? FN_SED : FN_CLD;
      else if (pick < 50) code = $urandom_range(1) ? FN_LDST : FN_RDST;
      else if (pick < 53) code = 5'($urandom_range(31, 26));
      else code = 5'($urandom_range(25));
      // Decimal arithmetic is exercised mostly with valid BCD bytes.
      if ($urandom_range(1)) op = {4'($urandom_range(9)), 4'($urandom_range(9))};
      else op = 8'($urandom_range(255));
      send_word(code, op);
    end
  endtask

  initial begin
    board = new();
    send_idle_pct = 7;
    recv_idle_pct = 49;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_NOP;
    in_ch.operand <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_directed();
    send_random(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 49;
    recv_idle_pct = 7;
    send_random(PHASE_WORDS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(PHASE_WORDS);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.failures == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
